// File: rtl/ppt_pkg.sv
// Shared types and constants for the peer presence table.
// Request, response and stored entry layouts, register indexes, event codes.
// No dependencies.
package ppt_pkg;

  localparam int TABLE_ENTRIES_DEFAULT = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [31:0] STALE_TIME_RESET    = 32'd75000;
  localparam logic [31:0] RESTART_GRACE_RESET = 32'd2000;

  // request kinds
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  // event codes
  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_UPDATE  = 3'd1;
  localparam logic [2:0] EV_NEW     = 3'd2;
  localparam logic [2:0] EV_IDENT   = 3'd3;
  localparam logic [2:0] EV_RESTART = 3'd4;

  typedef enum logic [0:0] {
    REG_STALE_TIME    = 1'b0,
    REG_RESTART_GRACE = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] now_ms;
    logic [47:0] peer_address;
    logic [7:0]  peer_type;
    logic [7:0]  peer_role;
    logic [15:0] profile_rev;
    logic [31:0] peer_uptime_ms;
  } req_t;

  typedef struct packed {
    logic [2:0] event_code;
    logic [2:0] slot_used;
    logic       refresh_request;
    logic [7:0] expired_mask;
    logic [3:0] active_count;
  } rsp_t;

  typedef struct packed {
    logic [47:0] address;
    logic [7:0]  peer_type;
    logic [7:0]  peer_role;
    logic [15:0] profile_rev;
    logic [31:0] uptime;
    logic [31:0] last_seen;
  } entry_t;

  typedef struct packed {
    logic match;   // valid entry holds the requested address
    logic expire;  // valid entry silent for at least the stale time
  } probe_t;

endpackage

// File: rtl/peer_presence_table.sv
// Peer presence table top level: request/response channels, config registers,
// walk sequencer and valid bits. Depends on ppt_pkg, ppt_ram and ppt_probe.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  ppt_pkg::req_t
//   rsp      out        rsp_valid / rsp_ready  ppt_pkg::rsp_t
//   cfg      in         cfg_write_en           cfg_index, cfg_data (32 bit)
//
// Each request is walked in full before the next one is accepted: the
// sequencer walks the entry RAM one slot per cycle through its single read
// port, evaluates one entry per cycle in the shared probe unit, then commits
// in the S_DONE state.
// Reset clears all valid bits, the active count and both config registers
// to their defaults; stored entry fields are only read behind a valid bit.
// A stalled response holds the commit cycle; a request is taken only while
// the sequencer is idle, even if the previous response still waits.
module peer_presence_table #(
  parameter int TABLE_ENTRIES = ppt_pkg::TABLE_ENTRIES_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_ready,
  input  ppt_pkg::req_t                   req,
  output logic                            rsp_valid,
  input  logic                            rsp_ready,
  output ppt_pkg::rsp_t                   rsp,
  input  logic                            cfg_write_en,
  input  ppt_pkg::cfg_index_t             cfg_index,
  input  logic [ppt_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ppt_pkg::*;

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,  // wait for a request
    S_WALK = 4'b0010,  // issue one RAM read per cycle
    S_LAST = 4'b0100,  // evaluate the final entry
    S_DONE = 4'b1000   // commit the write and post the response
  } state_t;

  state_t                  state;
  logic [IW-1:0]           rd_idx;
  logic                    ev_valid;
  logic [IW-1:0]           ev_idx;
  req_t                    req_q;
  logic [TABLE_ENTRIES-1:0] vld;
  logic [CW-1:0]           count;
  logic                    hit;
  logic [IW-1:0]           hit_slot;
  entry_t                  hit_entry;
  logic                    free_found;
  logic [IW-1:0]           free_slot;
  logic [7:0]              exp_mask;
  logic [31:0]             stale_time;
  logic [31:0]             restart_grace;

  // entry RAM and probe
  logic                    ram_we;
  entry_t                  ram_wdata;
  entry_t                  ram_rdata;
  probe_t                  probe;

  // commit-cycle datapath
  logic                    req_fire;
  logic                    done_fire;
  logic [IW-1:0]           slot;
  logic                    was_valid;
  logic                    ident_diff;
  logic [32:0]             up_sum;
  logic                    restarted;
  logic [2:0]              ev_code;
  logic [CW-1:0]           count_next;
  logic [CW+3:0]           count_ext;
  logic [IW+2:0]           slot_ext;
  logic [IW+2:0]           ev_ext;
  rsp_t                    rsp_next;

  assign req_ready = (state == S_IDLE);
  assign req_fire  = req_valid && req_ready;
  // commit only when the response register is free or draining this cycle
  assign done_fire = (state == S_DONE) && (!rsp_valid || rsp_ready);

  ppt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata (ram_wdata),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  ppt_probe u_probe (
    .kind        (req_q.kind),
    .key         (req_q.peer_address),
    .now         (req_q.now_ms),
    .stale_time  (stale_time),
    .entry       (ram_rdata),
    .entry_valid (vld[ev_idx]),
    .result      (probe)
  );

  // Resolve the target slot and classify the report from what the walk found.
  always_comb begin
    slot       = hit ? hit_slot : (free_found ? free_slot : '0);
    // a full-table miss lands on slot 0, which is valid
    was_valid  = hit || !free_found;
    ident_diff = (hit_entry.peer_type != req_q.peer_type) ||
                 (hit_entry.peer_role != req_q.peer_role) ||
                 (hit_entry.profile_rev != req_q.profile_rev);
    // unwrapped 33-bit sum for the restart test
    up_sum     = {1'b0, req_q.peer_uptime_ms} + {1'b0, restart_grace};
    restarted  = up_sum < {1'b0, hit_entry.uptime};

    priority if (!was_valid) begin
      ev_code = EV_NEW;
    end else if (!hit || ident_diff) begin
      ev_code = EV_IDENT;
    end else if (restarted) begin
      ev_code = EV_RESTART;
    end else begin
      ev_code = EV_UPDATE;
    end

    if ((req_q.kind == KIND_STATUS) && !was_valid) begin
      count_next = count + CW'(1);
    end else begin
      count_next = count;
    end
    count_ext = (CW + 4)'(count_next);
    slot_ext  = (IW + 3)'(slot);
    ev_ext    = (IW + 3)'(ev_idx);

    ram_we              = done_fire && (req_q.kind == KIND_STATUS);
    ram_wdata.address     = req_q.peer_address;
    ram_wdata.peer_type   = req_q.peer_type;
    ram_wdata.peer_role   = req_q.peer_role;
    ram_wdata.profile_rev = req_q.profile_rev;
    ram_wdata.uptime      = req_q.peer_uptime_ms;
    ram_wdata.last_seen   = req_q.now_ms;

    if (req_q.kind == KIND_TICK) begin
      rsp_next.event_code      = EV_NONE;
      rsp_next.slot_used       = '0;
      rsp_next.refresh_request = 1'b0;
      rsp_next.expired_mask    = exp_mask;
    end else begin
      rsp_next.event_code      = ev_code;
      rsp_next.slot_used       = slot_ext[2:0];
      rsp_next.refresh_request = (ev_code == EV_NEW) || (ev_code == EV_IDENT) ||
                                 (ev_code == EV_RESTART);
      rsp_next.expired_mask    = '0;
    end
    rsp_next.active_count = count_ext[3:0];
  end

  // Control state: sequencer, valid bits, counters, config registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      rd_idx        <= '0;
      ev_valid      <= 1'b0;
      vld           <= '0;
      count         <= '0;
      hit           <= 1'b0;
      free_found    <= 1'b0;
      rsp_valid     <= 1'b0;
      stale_time    <= STALE_TIME_RESET;
      restart_grace <= RESTART_GRACE_RESET;
    end else begin
      if (cfg_write_en) begin
        unique case (cfg_index)
          REG_STALE_TIME:    stale_time    <= cfg_data;
          REG_RESTART_GRACE: restart_grace <= cfg_data;
        endcase
      end

      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end

      // evaluate the entry whose read data just arrived
      if (ev_valid) begin
        if (probe.match && !hit) begin
          hit <= 1'b1;
        end
        if (!vld[ev_idx] && !free_found) begin
          free_found <= 1'b1;
        end
        if (probe.expire) begin
          vld[ev_idx] <= 1'b0;
          count       <= count - CW'(1);
        end
      end

      unique case (state)
        S_IDLE: begin
          if (req_fire) begin
            state      <= S_WALK;
            rd_idx     <= '0;
            hit        <= 1'b0;
            free_found <= 1'b0;
          end
        end
        S_WALK: begin
          ev_valid <= 1'b1;
          if (rd_idx == LAST_IDX) begin
            state <= S_LAST;
          end else begin
            rd_idx <= rd_idx + IW'(1);
          end
        end
        S_LAST: begin
          ev_valid <= 1'b0;
          state    <= S_DONE;
        end
        S_DONE: begin
          if (done_fire) begin
            rsp_valid <= 1'b1;
            count     <= count_next;
            if (req_q.kind == KIND_STATUS) begin
              vld[slot] <= 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Payload registers: captured request, walk findings, response.
  always_ff @(posedge clk) begin
    if (req_fire) begin
      req_q    <= req;
      exp_mask <= '0;
    end
    if (state == S_WALK) begin
      ev_idx <= rd_idx;
    end
    if (ev_valid) begin
      if (probe.match && !hit) begin
        hit_slot  <= ev_idx;
        hit_entry <= ram_rdata;
      end
      if (!vld[ev_idx] && !free_found) begin
        free_slot <= ev_idx;
      end
      // only the first eight slots are reported in the mask
      if (probe.expire && (ev_ext[IW+2:3] == '0)) begin
        exp_mask[ev_ext[2:0]] <= 1'b1;
      end
    end
    if (done_fire) begin
      rsp <= rsp_next;
    end
  end

`ifndef SYNTHESIS
  a_count_tracks_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(vld) == count)
    else $error("active count out of step with valid bits");

  a_accept_starts_walk: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> (state == S_WALK))
    else $error("accepted request did not start a walk");

  a_free_slot_is_free: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DONE) && free_found) |-> !vld[free_slot])
    else $error("recorded free slot is occupied");

  a_rsp_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == S_DONE))
    else $error("response posted outside the commit cycle");
`endif

endmodule

// File: rtl/ppt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Holds the per-slot entry records. No package dependencies.
module ppt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/ppt_probe.sv
// Per-entry compare unit shared by every step of the table walk.
// Uses ppt_pkg types; evaluates one stored entry against the current request.
module ppt_probe (
  input  logic            kind,
  input  logic [47:0]     key,
  input  logic [31:0]     now,
  input  logic [31:0]     stale_time,
  input  ppt_pkg::entry_t entry,
  input  logic            entry_valid,
  output ppt_pkg::probe_t result
);
  import ppt_pkg::*;

  logic [31:0] silence;

  always_comb begin
    // wrapping difference: time since the entry was last seen
    silence       = now - entry.last_seen;
    result.match  = entry_valid && (kind == KIND_STATUS) && (entry.address == key);
    result.expire = entry_valid && (kind == KIND_TICK) && (silence >= stale_time);
  end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for the peer presence table: random and directed status/tick requests,
// an in-bench mirror of the slot table and an in-order response scoreboard.
// Depends on ppt_pkg and the peer_presence_table RTL.
module testbench;
  import ppt_pkg::*;

  localparam int SLOTS     = TABLE_ENTRIES_DEFAULT;
  localparam int POOL      = 12;   // more peers than slots, so full-table misses happen
  localparam int PHASES    = 9;
  localparam int PER_PHASE = 170;
  localparam int MAX_SHOWN = 10;

  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  req_valid    = 1'b0;
  logic                  req_ready;
  req_t                  req          = '0;
  logic                  rsp_valid;
  logic                  rsp_ready    = 1'b0;
  rsp_t                  rsp;
  logic                  cfg_write_en = 1'b0;
  cfg_index_t            cfg_index    = REG_STALE_TIME;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;

  // Hold both sides busy-free while set (the long stretch without idling).
  logic calm = 1'b0;

  // Mirror of the block: per-slot valid bit and stored entry, plus both registers.
  logic        mirror_valid [SLOTS];
  entry_t      mirror_entry [SLOTS];
  logic [31:0] stale_limit;
  logic [31:0] grace_ms;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];

  // Peers that mostly behave well: stable identity, rising uptime, shared clock.
  logic [47:0] pool_addr [POOL];
  logic [7:0]  pool_type [POOL];
  logic [7:0]  pool_role [POOL];
  logic [15:0] pool_rev  [POOL];
  logic [31:0] pool_up   [POOL];
  logic [31:0] clock_ms;

  int mismatches = 0;
  int n_accepted = 0;
  int n_checked  = 0;
  int n_settings = 0;
  int n_freed    = 0;
  int ev_tally [5];

  peer_presence_table #(.TABLE_ENTRIES(SLOTS)) u_top (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .req          (req),
    .rsp_valid    (rsp_valid),
    .rsp_ready    (rsp_ready),
    .rsp          (rsp),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Work out the response to one request and advance the mirror table.
  function automatic rsp_t predict_presence(input req_t r);
    rsp_t        o;
    int          slot;
    int          live;
    bit          hit;
    bit          have_free;
    bit          was;
    bit          changed;
    logic [31:0] silence;
    logic [32:0] floor_up;
    o = '0;
    if (r.kind == KIND_TICK) begin
      // Free every valid slot silent for at least the stale time (wrapping difference).
      for (int i = 0; i < SLOTS; i++) begin
        silence = r.now_ms - mirror_entry[i].last_seen;
        if (mirror_valid[i] && silence >= stale_limit) begin
          mirror_valid[i] = 1'b0;
          if (i < 8) o.expired_mask[i] = 1'b1;
        end
      end
    end else begin
      // Hit on a valid slot first, else the lowest free slot, else slot 0.
      slot      = 0;
      hit       = 1'b0;
      have_free = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        if (!hit && mirror_valid[i] && mirror_entry[i].address == r.peer_address) begin
          slot = i;
          hit  = 1'b1;
        end
      end
      if (!hit) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!have_free && !mirror_valid[i]) begin
            slot      = i;
            have_free = 1'b1;
          end
        end
      end
      was     = mirror_valid[slot];
      changed = !was || mirror_entry[slot].address != r.peer_address ||
                mirror_entry[slot].peer_type != r.peer_type ||
                mirror_entry[slot].peer_role != r.peer_role ||
                mirror_entry[slot].profile_rev != r.profile_rev;
      // Restart test uses a 33-bit sum so a large uptime plus grace never wraps.
      floor_up = {1'b0, r.peer_uptime_ms} + {1'b0, grace_ms};
      if (!was)
        o.event_code = EV_NEW;
      else if (changed)
        o.event_code = EV_IDENT;
      else if (floor_up < {1'b0, mirror_entry[slot].uptime})
        o.event_code = EV_RESTART;
      else
        o.event_code = EV_UPDATE;
      o.refresh_request = (o.event_code != EV_UPDATE);
      o.slot_used       = slot[2:0];
      mirror_valid[slot]             = 1'b1;
      mirror_entry[slot].address     = r.peer_address;
      mirror_entry[slot].peer_type   = r.peer_type;
      mirror_entry[slot].peer_role   = r.peer_role;
      mirror_entry[slot].profile_rev = r.profile_rev;
      mirror_entry[slot].uptime      = r.peer_uptime_ms;
      mirror_entry[slot].last_seen   = r.now_ms;
    end
    live = 0;
    for (int i = 0; i < SLOTS; i++)
      if (mirror_valid[i]) live++;
    o.active_count = live[3:0];
    return o;
  endfunction

  function automatic void queue_status(input logic [31:0] now, input logic [47:0] addr,
                                       input logic [7:0] ptype, input logic [7:0] prole,
                                       input logic [15:0] rev, input logic [31:0] up);
    req_t r;
    r.kind           = KIND_STATUS;
    r.now_ms         = now;
    r.peer_address   = addr;
    r.peer_type      = ptype;
    r.peer_role      = prole;
    r.profile_rev    = rev;
    r.peer_uptime_ms = up;
    pending_reqs.push_back(r);
  endfunction

  // A tick carries junk in the status fields; the block must ignore it.
  function automatic void queue_tick(input logic [31:0] now);
    req_t        r;
    logic [63:0] wide;
    wide             = {$urandom, $urandom};
    r.kind           = KIND_TICK;
    r.now_ms         = now;
    r.peer_address   = wide[47:0];
    r.peer_type      = wide[55:48];
    r.peer_role      = wide[63:56];
    r.profile_rev    = 16'($urandom);
    r.peer_uptime_ms = $urandom;
    pending_reqs.push_back(r);
  endfunction

  // Mostly well-behaved peers on a shared clock, with ticks, noise and identity churn.
  function automatic void queue_traffic(input int count, input logic [31:0] max_advance);
    int          pick;
    int          roll;
    int          up_roll;
    logic [31:0] drop;
    logic [63:0] wide;
    for (int k = 0; k < count; k++) begin
      roll = $urandom_range(99);
      if (roll < 3)
        clock_ms += $urandom;
      else
        clock_ms += $urandom_range(max_advance);
      if (roll < 13) begin
        queue_tick(clock_ms);
      end else if (roll < 18) begin
        wide = {$urandom, $urandom};
        queue_status($urandom, wide[47:0], wide[55:48], wide[63:56], 16'($urandom),
                     $urandom);
      end else begin
        pick = $urandom_range(POOL - 1);
        roll = $urandom_range(99);
        if (roll < 4) begin
          // Replace the peer with a stranger.
          wide            = {$urandom, $urandom};
          pool_addr[pick] = wide[47:0];
          pool_type[pick] = wide[55:48];
          pool_role[pick] = wide[63:56];
          pool_rev[pick]  = 16'($urandom);
        end else if (roll < 10) begin
          case ($urandom_range(2))
            0:       pool_type[pick] = 8'($urandom);
            1:       pool_role[pick] = 8'($urandom);
            default: pool_rev[pick]  = 16'($urandom);
          endcase
        end
        up_roll = $urandom_range(99);
        if (up_roll < 8) begin
          pool_up[pick] = $urandom;
        end else if (up_roll < 20) begin
          // Drop the uptime by an amount straddling the grace.
          drop = (grace_ms > 32'd100000) ? $urandom : $urandom_range(2 * grace_ms + 2);
          pool_up[pick] -= drop;
        end else begin
          pool_up[pick] += $urandom_range(max_advance);
        end
        queue_status(clock_ms, pool_addr[pick], pool_type[pick], pool_role[pick],
                     pool_rev[pick], pool_up[pick]);
      end
    end
  endfunction

  // Write one register; the mirror follows at the same edge, with nothing in flight.
  task automatic write_reg(input cfg_index_t idx, input logic [31:0] value);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    if (idx == REG_STALE_TIME)
      stale_limit = value;
    else
      grace_ms = value;
  endtask

  // Wait until every queued request has been taken and every response checked.
  task automatic drain();
    while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || req_valid)
      @(negedge clk);
  endtask

  // Request driver: hold valid and payload until taken, then sometimes idle before the next.
  always @(posedge clk) begin : drive_requests
    logic busy;
    rsp_t predicted;
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      busy = req_valid && !req_ready;
      if (req_valid && req_ready) begin
        predicted = predict_presence(req);
        expected_rsps.push_back(predicted);
        n_accepted++;
        ev_tally[predicted.event_code]++;
        n_freed += $countones(predicted.expired_mask);
      end
      if (!busy) begin
        if (pending_reqs.size() != 0 && (calm || $urandom_range(99) >= 16)) begin
          req       <= pending_reqs.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor: compare each taken response with the oldest prediction.
  always @(posedge clk) begin : check_responses
    rsp_t want;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("%0t: response with no request outstanding: ev=%0d slot=%0d", $realtime,
                     rsp.event_code, rsp.slot_used);
        end else begin
          want = expected_rsps.pop_front();
          n_checked++;
          if (rsp.event_code !== want.event_code || rsp.slot_used !== want.slot_used ||
              rsp.refresh_request !== want.refresh_request ||
              rsp.expired_mask !== want.expired_mask ||
              rsp.active_count !== want.active_count) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
              $display({"%0t: response %0d expected ev=%0d slot=%0d refresh=%0b ",
                        "expired=%02h active=%0d, got ev=%0d slot=%0d refresh=%0b ",
                        "expired=%02h active=%0d"}, $realtime, n_checked,
                       want.event_code, want.slot_used, want.refresh_request,
                       want.expired_mask, want.active_count, rsp.event_code,
                       rsp.slot_used, rsp.refresh_request, rsp.expired_mask,
                       rsp.active_count);
          end
        end
      end
      rsp_ready <= calm || ($urandom_range(99) >= 16);
    end
  end

  initial begin : stimulus
    logic [31:0] t;
    logic [31:0] stale;
    logic [31:0] grace;
    logic [31:0] max_advance;
    logic [63:0] wide;
    for (int i = 0; i < SLOTS; i++) begin
      mirror_valid[i] = 1'b0;
      mirror_entry[i] = '0;
    end
    for (int i = 0; i < 5; i++) ev_tally[i] = 0;
    stale_limit = STALE_TIME_RESET;
    grace_ms    = RESTART_GRACE_RESET;
    clock_ms    = $urandom;
    for (int i = 0; i < POOL; i++) begin
      wide         = {$urandom, $urandom};
      pool_addr[i] = wide[47:0];
      pool_type[i] = wide[55:48];
      pool_role[i] = wide[63:56];
      pool_rev[i]  = 16'($urandom);
      pool_up[i]   = $urandom;
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset register values; the clock wraps through zero early on.
    t = 32'hFFFF_FFF0;
    queue_status(t,        48'hFFFF_FFFF_FFFF, 8'hFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
    queue_status(t + 2,    48'h0, 8'h00, 8'h00, 16'h0000, 32'd0);        // new, slot 1
    queue_status(t + 4,    48'h0, 8'h00, 8'h00, 16'h0000, 32'd0);        // plain update
    queue_status(t + 6,    48'hFFFF_FFFF_FFFF, 8'hFF, 8'hFF, 16'hFFFF, 32'd0); // restart
    queue_status(t + 8,    48'hFFFF_FFFF_FFFF, 8'hFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
    queue_status(t + 10,   48'h0, 8'h00, 8'h00, 16'h0000, 32'd5000);
    queue_status(t + 12,   48'h0, 8'h00, 8'h00, 16'h0000, 32'd3000);     // drop equals grace
    queue_status(t + 14,   48'h0, 8'h00, 8'h00, 16'h0000, 32'd999);      // one past grace
    queue_status(t + 16,   48'h0, 8'h00, 8'h01, 16'h0000, 32'd1000);     // role changed
    queue_status(t + 18,   48'h0, 8'h80, 8'h01, 16'h0000, 32'd1000);     // type changed
    queue_status(t + 20,   48'h0, 8'h80, 8'h01, 16'h8000, 32'd1000);     // revision changed
    // Fill the remaining slots, then miss on a full table.
    for (int k = 0; k < 6; k++)
      queue_status(t + 22 + 2 * k, 48'h1 << (7 * k + 3), 8'(k), 8'(~k), 16'(k * 257),
                   32'(k * 1000));
    queue_status(t + 34,   48'hA5A5_5A5A_0F0F, 8'h12, 8'h34, 16'h5678, 32'd42);
    queue_tick(32'd100);                    // silence tiny across the wrap: nothing freed
    queue_tick(t + 20 + 32'd75000);         // exactly stale for slot 1: partial mask
    queue_tick(32'h7FFF_FFFF);              // everything left goes
    queue_tick(32'h8000_0000);              // empty table
    queue_status(32'h8000_0010, 48'hFFFF_FFFF_FFFF, 8'hFF, 8'hFF, 16'hFFFF, 32'd7);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      max_advance = 32'd3000;
      case (p)
        0: begin
          stale = 32'd1;
          grace = 32'd0;
        end
        1: begin
          stale = 32'hFFFF_FFFF;
          grace = 32'hFFFF_FFFF;
        end
        2: begin
          stale = 32'd0;     // every valid entry goes on each tick
          grace = RESTART_GRACE_RESET;
        end
        3: begin
          stale       = STALE_TIME_RESET;
          grace       = RESTART_GRACE_RESET;
          max_advance = 32'd20000;
        end
        default: begin
          stale = $urandom_range(30000, 1000);
          grace = $urandom_range(5000, 0);
        end
      endcase
      write_reg(REG_STALE_TIME, stale);
      write_reg(REG_RESTART_GRACE, grace);
      n_settings++;
      calm <= (p == 6);
      queue_traffic(PER_PHASE, max_advance);
      drain();
    end
    calm <= 1'b0;

    // Let any stray response show up before the verdict.
    repeat (40) @(posedge clk);
    mismatches += expected_rsps.size();

    $display("Ran %0d requests over %0d register settings plus reset values: %0d new, %0d updates,",
             n_accepted, n_settings, ev_tally[EV_NEW], ev_tally[EV_UPDATE]);
    $display("%0d identity changes, %0d restarts, %0d ticks freeing %0d entries; %0d checked.",
             ev_tally[EV_IDENT], ev_tally[EV_RESTART], ev_tally[EV_NONE], n_freed, n_checked);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Stop a hung run; a clean run needs only a fraction of this.
  initial begin : watchdog
    #6ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: sim.f
rtl/ppt_pkg.sv
rtl/ppt_ram.sv
rtl/ppt_probe.sv
rtl/peer_presence_table.sv
verif/testbench.sv
